@@ sv/plm_pkg.sv @@
// shared types, codes and constants of the peak level meter
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package plm_pkg;

    // sample size codes
    localparam logic [1:0] SIZE_8    = 2'd0;
    localparam logic [1:0] SIZE_16   = 2'd1;
    localparam logic [1:0] SIZE_32   = 2'd2;
    localparam logic [1:0] SIZE_NONE = 2'd3;

    // sample kind codes
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SIZE       = 2'd0;
    localparam logic [1:0] CFG_KIND       = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;
    localparam logic [1:0] CFG_CHANNELS   = 2'd3;

    // port and field widths
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int CHAN_CNT_W  = 4;
    localparam int CHAN_CMP_W  = 5;
    localparam int SAMPLE_W    = 32;
    localparam int TOTAL_W     = 16;
    localparam int LEVEL_W     = 17;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // divider: one quotient bit per cycle
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [1:0]            size;
        logic [1:0]            kind;
        logic                  big_endian;
        logic [CHAN_CNT_W-1:0] chans;
    } t_cfg;

    // one finished buffer waiting for normalization
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] scale;
        logic                fmt_ok;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // full scale of a format
    function automatic logic [SAMPLE_W-1:0] full_scale(input logic [1:0] size,
                                                       input logic [1:0] kind);
        logic [SAMPLE_W-1:0] fs;
        fs = 32'h7fffffff;
        case (size)
            SIZE_8:  fs = (kind == KIND_UNSIGNED) ? 32'd255 : 32'd127;
            SIZE_16: fs = (kind == KIND_UNSIGNED) ? 32'd65535 : 32'd32767;
            default: fs = (kind == KIND_UNSIGNED) ? 32'hffffffff : 32'h7fffffff;
        endcase
        return fs;
    endfunction

endpackage

@@ sv/plm_queue.sv @@
// short job queue between the sample front end and the normalizing back end
// depends on plm_pkg for the job type and depth
`timescale 1ns / 1ps

module plm_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  plm_pkg::t_job             i_job,
    input  logic                      i_pop,
    output plm_pkg::t_job             o_job,
    output logic [plm_pkg::QCNT_W-1:0] o_count
);

    plm_pkg::t_job                r_slot [plm_pkg::QUEUE_DEPTH];
    logic [plm_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [plm_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [plm_pkg::QCNT_W-1:0]   r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_job;
    end

    assign o_job   = r_slot[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ sv/plm_front.sv @@
// front end: accepts sample words, decodes them, tracks frame position and peak
// pushes one job per finished buffer; depends on plm_pkg
`timescale 1ns / 1ps

module plm_front #(
    parameter int MAX_CHANNELS     = 8,
    parameter int PROBE_FRAMES     = 50,
    parameter int FRAME_COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  plm_pkg::t_cfg                      i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [plm_pkg::SAMPLE_W-1:0]       i_word,
    input  logic [plm_pkg::TOTAL_W-1:0]        i_total,
    input  logic                               i_last,
    input  logic [plm_pkg::QCNT_W-1:0]         i_q_count,
    output logic                               o_push,
    output plm_pkg::t_job                      o_job
);

    localparam int FB       = FRAME_COUNT_BITS;
    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PB       = $clog2(PROBE_FRAMES + 1);
    localparam int PHW      = FB + 1 + PB;
    localparam int SW       = plm_pkg::SAMPLE_W;
    localparam int CW       = plm_pkg::CHAN_CMP_W;

    // frame and channel counters
    logic [CH_IDX_W-1:0] r_chan, n_chan;
    logic [FB-1:0]       r_frame, n_frame;
    logic [FB-1:0]       r_phase, n_phase;

    // decode stage register
    logic          r_s1_valid;
    logic          r_s1_last;
    logic          r_s1_take;
    logic          r_s1_live;
    logic          r_s1_ok;
    logic [SW-1:0] r_s1_mag;
    logic [SW-1:0] r_s1_scale;

    // running peak
    logic [SW-1:0] r_peak, n_peak;

    logic          accept;
    logic          fmt_ok;
    logic [FB-1:0] total;
    logic          take;
    logic [SW-1:0] mag;

    // room for this word and a buffer end still in the decode stage
    always_comb begin
        o_ready = ({1'b0, i_q_count} + {{plm_pkg::QCNT_W{1'b0}},
                  (r_s1_valid & r_s1_last)}) < (plm_pkg::QCNT_W + 1)'(plm_pkg::QUEUE_DEPTH);
    end
    assign accept = i_valid & o_ready;

    // format check
    always_comb begin
        fmt_ok = (i_cfg.size != plm_pkg::SIZE_NONE) && (i_cfg.kind != plm_pkg::KIND_NONE)
               && !((i_cfg.kind == plm_pkg::KIND_FLOAT) && (i_cfg.size != plm_pkg::SIZE_32))
               && (i_cfg.chans != '0)
               && ({1'b0, i_cfg.chans} <= CW'(MAX_CHANNELS));
    end

    // frame total trimmed to the counter width
    always_comb begin
        total = '0;
        for (int i = 0; i < FB; i++) begin
            if (i < plm_pkg::TOTAL_W) total[i] = i_total[i];
        end
    end

    // sample decoding
    always_comb begin
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] w16, neg16;
        logic [31:0] w32, neg32;
        logic [7:0]  neg8;
        logic [7:0]  expo, e_eff, shamt;
        logic [23:0] mant;
        logic [54:0] prod;
        logic [54:0] shifted;
        b0 = i_word[7:0];
        b1 = i_word[15:8];
        b2 = i_word[23:16];
        b3 = i_word[31:24];
        w16 = i_cfg.big_endian ? {b0, b1} : {b1, b0};
        w32 = i_cfg.big_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
        neg8  = 8'd0 - b0;
        neg16 = 16'd0 - w16;
        neg32 = 32'd0 - w32;
        // float: |x| * (2^31 - 1) as (m << 31) - m, then scaled down
        expo  = w32[30:23];
        e_eff = (expo == 8'd0) ? 8'd1 : expo;
        mant  = {(expo != 8'd0), w32[22:0]};
        shamt = 8'd150 - e_eff;
        prod  = {mant, 31'd0} - {31'd0, mant};
        shifted = prod >> shamt[5:0];
        mag = '0;
        unique case (i_cfg.size)
            plm_pkg::SIZE_8: begin
                if (i_cfg.kind == plm_pkg::KIND_UNSIGNED || !b0[7]) mag = {24'd0, b0};
                else if (neg8[7])                                   mag = 32'd127;
                else                                                mag = {24'd0, neg8};
            end
            plm_pkg::SIZE_16: begin
                if (i_cfg.kind == plm_pkg::KIND_UNSIGNED || !w16[15]) mag = {16'd0, w16};
                else if (neg16[15])                                   mag = 32'd32767;
                else                                                  mag = {16'd0, neg16};
            end
            plm_pkg::SIZE_32: begin
                if (i_cfg.kind == plm_pkg::KIND_FLOAT) begin
                    if (expo >= 8'd127)      mag = 32'h7fffffff;
                    else if (shamt >= 8'd64) mag = '0;
                    else                     mag = shifted[31:0];
                end else if (i_cfg.kind == plm_pkg::KIND_UNSIGNED || !w32[31]) begin
                    mag = w32;
                end else if (neg32[31]) begin
                    mag = 32'h7fffffff;
                end else begin
                    mag = neg32;
                end
            end
            default: mag = '0;
        endcase
    end

    assign take = fmt_ok && (total != '0) && (r_frame < total) && (r_phase == '0);

    // counter update
    always_comb begin
        logic [CW-1:0]  chans_eff;
        logic [CW-1:0]  chan_inc;
        logic [FB:0]    phase_inc;
        logic [PHW-1:0] reach;
        chans_eff = fmt_ok ? {1'b0, i_cfg.chans} : CW'(1);
        chan_inc  = CW'(r_chan) + CW'(1);
        phase_inc = {1'b0, r_phase} + (FB + 1)'(1);
        reach     = PHW'(phase_inc) * PHW'(PROBE_FRAMES);
        n_chan  = r_chan;
        n_frame = r_frame;
        n_phase = r_phase;
        if (chan_inc >= chans_eff) begin
            n_chan = '0;
            if (r_frame != '1) n_frame = r_frame + 1'b1;
            // wrap once phase + 1 reaches total / PROBE_FRAMES + 1
            if (reach > PHW'(total)) n_phase = '0;
            else                     n_phase = phase_inc[FB-1:0];
        end else begin
            n_chan = chan_inc[CH_IDX_W-1:0];
        end
        if (i_last) begin
            n_chan  = '0;
            n_frame = '0;
            n_phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan     <= '0;
            r_frame    <= '0;
            r_phase    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_chan  <= n_chan;
                r_frame <= n_frame;
                r_phase <= n_phase;
            end
        end
    end

    // decode stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last  <= i_last;
            r_s1_take  <= take;
            r_s1_live  <= fmt_ok && (total != '0);
            r_s1_ok    <= fmt_ok;
            r_s1_mag   <= mag;
            r_s1_scale <= plm_pkg::full_scale(i_cfg.size, i_cfg.kind);
        end
    end

    // peak update and job build
    always_comb begin
        logic [SW-1:0] clamped;
        n_peak  = (r_s1_take && (r_s1_mag > r_peak)) ? r_s1_mag : r_peak;
        clamped = (n_peak > r_s1_scale) ? r_s1_scale : n_peak;
        o_push        = r_s1_valid & r_s1_last;
        o_job.peak    = r_s1_live ? clamped : '0;
        o_job.scale   = r_s1_scale;
        o_job.fmt_ok  = r_s1_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (r_s1_valid) begin
            r_peak <= r_s1_last ? '0 : n_peak;
        end
    end

endmodule

@@ sv/plm_back.sv @@
// back end: restoring divider that turns a clamped peak into a Q1.16 level
// plus the result register; depends on plm_pkg
`timescale 1ns / 1ps

module plm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_avail,
    input  plm_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [plm_pkg::OUT_TDATA_W-1:0]     o_data
);

    localparam int SW = plm_pkg::SAMPLE_W;
    localparam int LW = plm_pkg::LEVEL_W;

    plm_pkg::t_back_state r_state, n_state;

    logic [plm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [SW-1:0]                 r_rem;
    logic [SW-1:0]                 r_den;
    logic [SW-1:0]                 r_peak;
    logic [LW-1:0]                 r_quo;
    logic                          r_ok;

    logic                          r_out_valid;
    logic [plm_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                          load_out;
    logic                          last_step;
    logic [SW:0]                   trial;
    logic                          ge;

    assign last_step = (r_cnt == plm_pkg::DIV_CNT_W'(plm_pkg::DIV_STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plm_pkg::BK_IDLE: if (i_avail)   n_state = plm_pkg::BK_DIV;
            plm_pkg::BK_DIV:  if (last_step) n_state = plm_pkg::BK_DONE;
            plm_pkg::BK_DONE: if (load_out)  n_state = plm_pkg::BK_IDLE;
            default:                         n_state = plm_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            plm_pkg::BK_IDLE: o_pop    = i_avail;
            plm_pkg::BK_DONE: load_out = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= plm_pkg::BK_IDLE;
        else          r_state <= n_state;
    end

    // one quotient bit per cycle; first step compares the peak unshifted
    always_comb begin
        trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= i_job.peak;
            r_den  <= i_job.scale;
            r_peak <= i_job.peak;
            r_ok   <= i_job.fmt_ok;
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (r_state == plm_pkg::BK_DIV) begin
            r_rem <= ge ? SW'(trial - {1'b0, r_den}) : trial[SW-1:0];
            r_quo <= {r_quo[LW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {{(plm_pkg::OUT_TDATA_W - LW - SW - 1){1'b0}}, r_ok, r_peak, r_quo};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

@@ sv/audio_peak_level_meter.sv @@
// result path: the last word passes the decode stage register and the job queue,
//   then the back end divides and its result register drives the level word
// throughput: one sample word per cycle while the job queue has room; each buffer end
//   costs the back end a 17-step division; a 4-entry job queue absorbs short buffers
// reset: synchronous active low; clears counters, peak, queue, divider and the
//   output valid, and sets the format registers to 16 bit signed little endian mono
`timescale 1ns / 1ps

module audio_peak_level_meter #(
    parameter int MAX_CHANNELS     = 8,
    parameter int PROBE_FRAMES     = 50,
    parameter int FRAME_COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample input
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sample_word [31:0], frame_total [47:32]
    input  logic [plm_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // buffer_end
    input  logic                                i_s_axis_tlast,
    // level output
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // level_fraction [16:0], peak_value [48:17], format_valid [49], zero [55:50]
    output logic [plm_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [plm_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [plm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    plm_pkg::t_cfg                r_cfg;
    plm_pkg::t_job                front_job;
    plm_pkg::t_job                head_job;
    logic                         push;
    logic                         pop;
    logic [plm_pkg::QCNT_W-1:0]   q_count;

    // format registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size       <= plm_pkg::SIZE_16;
            r_cfg.kind       <= plm_pkg::KIND_SIGNED;
            r_cfg.big_endian <= 1'b0;
            r_cfg.chans      <= plm_pkg::CHAN_CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                plm_pkg::CFG_SIZE:       r_cfg.size       <= i_cfg_wdata[1:0];
                plm_pkg::CFG_KIND:       r_cfg.kind       <= i_cfg_wdata[1:0];
                plm_pkg::CFG_BIG_ENDIAN: r_cfg.big_endian <= i_cfg_wdata[0];
                plm_pkg::CFG_CHANNELS:   r_cfg.chans      <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // sample decode and peak tracking
    plm_front #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .PROBE_FRAMES     (PROBE_FRAMES),
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_word    (i_s_axis_tdata[31:0]),
        .i_total   (i_s_axis_tdata[47:32]),
        .i_last    (i_s_axis_tlast),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (front_job)
    );

    // finished buffers waiting for division
    plm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_count (q_count)
    );

    // normalization and result word
    plm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_count != '0),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

@@ sv/plm_checker.sv @@
// port-level checks of the peak level meter result stream
// depends on plm_pkg; bound to audio_peak_level_meter below
`timescale 1ns / 1ps

module plm_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [plm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // level never exceeds 1.0
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[16:0] <= 17'd65536)
        else $error("level above full scale");

    // unsupported format reports silence
    a_bad_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[49]
            |-> o_m_axis_tdata[48:0] == 49'd0)
        else $error("nonzero result for unsupported format");

    // zero peak gives zero level
    a_zero_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[48:17] == 32'd0
            |-> o_m_axis_tdata[16:0] == 17'd0)
        else $error("level without peak");

endmodule

bind audio_peak_level_meter plm_port_checks u_plm_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
